@@ hdl/assert_macros.svh @@
// Assertion helpers for the enumerator RTL.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping or next-cycle property, clocked and gated by reset.
`define BFWE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Invariant that must hold at every sampled edge out of reset.
`define BFWE_ASSERT_ALWAYS(label, expr, msg) \
  `BFWE_ASSERT(label, (expr), msg)

`endif

@@ hdl/bfwe_pkg.sv @@
package bfwe_pkg;

  // Widths fixed by the field and register definitions
  localparam int DigitW  = 6;
  localparam int LenCfgW = 7;
  localparam int PosW    = 6;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOWER_INDEX = 2'd0,
    REG_UPPER_INDEX = 2'd1,
    REG_MIN_LENGTH  = 2'd2,
    REG_MAX_LENGTH  = 2'd3
  } cfg_reg_e;

endpackage

@@ hdl/bfwe_digit_ram.sv @@
// Digit store: one write port, one read port with registered read data.
module bfwe_digit_ram #(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [bfwe_pkg::DigitW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [bfwe_pkg::DigitW-1:0] rdata_o
);

  logic [bfwe_pkg::DigitW-1:0] mem_q [Depth];
  logic [bfwe_pkg::DigitW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/brute_force_word_enumerator.sv @@
// Candidate word enumerator, a variable-length odometer over digit indices.
// Input stream (s_axis): one transfer is one advance request; tdata[0] is
// restart, which clears the word so that this advance emits the first word.
// Output stream (m_axis): one transfer per digit, leftmost first; tlast marks
// the final digit of the word, tuser set means exhausted (single transfer).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 lower_index, 1 upper_index, 2 min_length, 3 max_length); write only idle.
// Operation: the digits live in a single-port-write, registered-read RAM that a
// small sequencer walks. A first word is filled digit by digit with the lower
// index; a later advance walks the carry from the rightmost digit, reading,
// then comparing and writing each digit that it passes, and grows the word by
// one digit when the carry runs out. Emission then primes the read and loads
// the digits one at a time into the output register. An exhausted report
// answers a request made once exhausted, or ends a carry that runs out at the
// length limit. s_axis_tready is high only idle.
// An output register sits between the sequencer and m_axis: the next advance
// is accepted while the last digit still waits; a stalled receiver holds the
// sequencer in its emit step with no loss. Reset clears the word (no word
// yet), the exhausted flag and the registers to their defaults.
module brute_force_word_enumerator #(
  parameter int MAX_WORD     = 32,
  parameter int CHARSET_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [bfwe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfwe_pkg::LenCfgW-1:0]  cfg_data_i,
  // Advance requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] restart, [7:1] zero
  // Word digits
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [5:0] digit_index, [11:6] position
  output logic                          m_axis_tlast,  // last_digit
  output logic                          m_axis_tuser   // exhausted
);

  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam logic [bfwe_pkg::LenCfgW-1:0] MaxWordCfg = bfwe_pkg::LenCfgW'(MAX_WORD);
  localparam logic [8:0] TopIdx = 9'(CHARSET_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CARRY_RD,
    ST_CARRY_CHK,
    ST_GROW,
    ST_PRIME,
    ST_EMIT,
    ST_EXH
  } state_e;

  // Configuration registers
  logic [bfwe_pkg::DigitW-1:0]  lower_q, upper_q;
  logic [bfwe_pkg::LenCfgW-1:0] min_len_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= '0;
      upper_q   <= '1;
      min_len_q <= bfwe_pkg::LenCfgW'(1);
      max_len_q <= bfwe_pkg::LenCfgW'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfwe_pkg::REG_LOWER_INDEX: lower_q   <= cfg_data_i[bfwe_pkg::DigitW-1:0];
        bfwe_pkg::REG_UPPER_INDEX: upper_q   <= cfg_data_i[bfwe_pkg::DigitW-1:0];
        bfwe_pkg::REG_MIN_LENGTH:  min_len_q <= cfg_data_i;
        bfwe_pkg::REG_MAX_LENGTH:  max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e                      state_q;
  logic [LW-1:0]               len_q;
  logic                        done_q;
  logic [AW-1:0]               idx_q;

  // Output register
  logic                        out_valid_q;
  logic [bfwe_pkg::DigitW-1:0] out_digit_q;
  logic [bfwe_pkg::PosW-1:0]   out_pos_q;
  logic                        out_last_q;
  logic                        out_exh_q;

  // Digit RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bfwe_pkg::DigitW-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [bfwe_pkg::DigitW-1:0] ram_rdata;

  bfwe_digit_ram #(
    .Depth (MAX_WORD),
    .AddrW (AW)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake terms
  logic in_xfer, out_free, emit_load, exh_load, pos_last, at_limit;
  logic [bfwe_pkg::DigitW-1:0]  wrap_pt;
  logic [bfwe_pkg::LenCfgW-1:0] start_len;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit_load     = (state_q == ST_EMIT) && out_free;
  assign exh_load      = (state_q == ST_EXH) && out_free;
  assign pos_last      = (LW'(idx_q) + LW'(1)) == len_q;

  // Wrap point: upper bound limited to the character set
  assign wrap_pt = ({3'b000, upper_q} < TopIdx) ? upper_q : TopIdx[bfwe_pkg::DigitW-1:0];

  // Starting length clamped to 1..MAX_WORD
  always_comb begin
    start_len = min_len_q;
    if (min_len_q == '0) begin
      start_len = bfwe_pkg::LenCfgW'(1);
    end else if (min_len_q > MaxWordCfg) begin
      start_len = MaxWordCfg;
    end
  end

  // Growth stops at max_length or at the storage size
  assign at_limit = (bfwe_pkg::LenCfgW'(len_q) >= max_len_q) || (len_q >= LW'(MAX_WORD));

  // RAM write and read address selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = lower_q;
    ram_raddr = idx_q;
    case (state_q)
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_CARRY_CHK: begin
        ram_we = 1'b1;
        if (ram_rdata != wrap_pt) begin
          ram_wdata = ram_rdata + bfwe_pkg::DigitW'(1);
        end
      end
      ST_GROW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(len_q);
      end
      ST_PRIME: begin
        ram_raddr = '0;
      end
      ST_EMIT: begin
        if (emit_load && !pos_last) begin
          ram_raddr = idx_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_digit_q <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
      out_exh_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !emit_load && !exh_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tdata[0]) begin
              len_q   <= LW'(start_len);
              done_q  <= 1'b0;
              idx_q   <= '0;
              state_q <= ST_FILL;
            end else if (done_q) begin
              state_q <= ST_EXH;
            end else if (len_q == '0) begin
              len_q   <= LW'(start_len);
              idx_q   <= '0;
              state_q <= ST_FILL;
            end else begin
              idx_q   <= AW'(len_q - LW'(1));
              state_q <= ST_CARRY_RD;
            end
          end
        end
        ST_FILL: begin
          if (pos_last) begin
            state_q <= ST_PRIME;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        ST_CARRY_RD: begin
          state_q <= ST_CARRY_CHK;
        end
        ST_CARRY_CHK: begin
          if (ram_rdata != wrap_pt) begin
            state_q <= ST_PRIME;
          end else if (idx_q != '0) begin
            idx_q   <= idx_q - AW'(1);
            state_q <= ST_CARRY_RD;
          end else if (at_limit) begin
            done_q  <= 1'b1;
            state_q <= ST_EXH;
          end else begin
            state_q <= ST_GROW;
          end
        end
        ST_GROW: begin
          len_q   <= len_q + LW'(1);
          state_q <= ST_PRIME;
        end
        ST_PRIME: begin
          idx_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_digit_q <= ram_rdata;
            out_pos_q   <= bfwe_pkg::PosW'(idx_q);
            out_last_q  <= pos_last;
            out_exh_q   <= 1'b0;
            if (pos_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end
        end
        ST_EXH: begin
          if (exh_load) begin
            out_valid_q <= 1'b1;
            out_digit_q <= '0;
            out_pos_q   <= '0;
            out_last_q  <= 1'b1;
            out_exh_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_pos_q, out_digit_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_exh_q;

  // Checks
  `include "assert_macros.svh"

  `BFWE_ASSERT_ALWAYS(a_len_bound, len_q <= LW'(MAX_WORD), "word length beyond storage")
  `BFWE_ASSERT(a_exh_shape, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0),
    "exhausted transfer not a lone zero digit")
  `BFWE_ASSERT(a_restart_fill, in_xfer && s_axis_tdata[0] |=> state_q == ST_FILL,
    "restart did not rebuild the starting word")
  `BFWE_ASSERT(a_done_sticky, done_q && !in_xfer |=> done_q,
    "exhausted flag dropped without a request")
  `BFWE_ASSERT(a_chk_in_word, state_q == ST_CARRY_CHK |-> LW'(idx_q) < len_q,
    "carry walk outside the word")

endmodule

@@ verif/brute_force_word_enumerator_test.sv @@
module brute_force_word_enumerator_test;

  localparam int MAX_WORD   = 32;
  localparam int CHARSET    = 64;
  localparam int QUIET_MAX  = 5000;
  localparam int SETTLE_CYC = 16;
  localparam int RAND_ITEMS = 200;

  // One digit transfer as the block should present it
  typedef struct packed {
    logic [bfwe_pkg::DigitW-1:0] digit;
    logic [bfwe_pkg::PosW-1:0]   pos;
    logic                        last;
    logic                        exhausted;
  } digit_rec_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [bfwe_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [bfwe_pkg::LenCfgW-1:0]  cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // [0] restart, [7:1] zero
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;        // [5:0] digit_index, [11:6] position
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  brute_force_word_enumerator #(
    .MAX_WORD    (MAX_WORD),
    .CHARSET_SIZE(CHARSET)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Odometer mirror and its register copies
  logic [bfwe_pkg::DigitW-1:0]  word_q [MAX_WORD];
  int                           word_len = 0;
  bit                           word_spent = 1'b0;
  logic [bfwe_pkg::DigitW-1:0]  lo_cfg = '0;
  logic [bfwe_pkg::DigitW-1:0]  hi_cfg = 6'd63;
  logic [bfwe_pkg::LenCfgW-1:0] min_cfg = 7'd1;
  logic [bfwe_pkg::LenCfgW-1:0] max_cfg = 7'd32;

  logic       advance_q [$];   // restart flags waiting to be sent
  digit_rec_t digits_due [$];  // digits expected from the block, oldest first

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  adv_taken = 1'b0;
  int  mismatches = 0;
  int  quiet = 0;
  int  n_adv = 0;
  int  n_digits = 0;
  int  n_spent = 0;
  int  n_settings = 0;

  // Step the odometer once and queue the digits the block must emit
  function automatic void advance_word(input logic restart);
    int i;
    int n;
    bit carry_out;
    logic [bfwe_pkg::DigitW-1:0] wrap;
    digit_rec_t rec;
    wrap = (int'(hi_cfg) < CHARSET - 1) ? hi_cfg : bfwe_pkg::DigitW'(CHARSET - 1);
    if (restart) begin
      word_len = 0;
      word_spent = 1'b0;
    end
    if (!word_spent) begin
      if (word_len == 0) begin
        // fresh word of lower digits, length clamped to 1..MAX_WORD
        n = (min_cfg < 1) ? 1 : ((min_cfg > MAX_WORD) ? MAX_WORD : int'(min_cfg));
        for (i = 0; i < n; i++) word_q[i] = lo_cfg;
        word_len = n;
      end else begin
        carry_out = 1'b1;
        for (i = word_len - 1; i >= 0 && carry_out; i--) begin
          if (word_q[i] != wrap) begin
            word_q[i] = word_q[i] + 1'b1;
            carry_out = 1'b0;
          end else begin
            word_q[i] = lo_cfg;
          end
        end
        // carry out of the leftmost digit: grow or give up
        if (carry_out) begin
          if (word_len >= max_cfg || word_len >= MAX_WORD) begin
            word_spent = 1'b1;
          end else begin
            word_q[word_len] = lo_cfg;
            word_len++;
          end
        end
      end
    end
    if (word_spent) begin
      rec = '{digit: '0, pos: '0, last: 1'b1, exhausted: 1'b1};
      digits_due.push_back(rec);
      n_spent++;
    end else begin
      for (i = 0; i < word_len; i++) begin
        rec = '{digit: word_q[i], pos: bfwe_pkg::PosW'(i), last: (i + 1 == word_len),
                exhausted: 1'b0};
        digits_due.push_back(rec);
      end
    end
  endfunction

  // Input side: note each accepted advance and predict its digits
  always @(posedge clk_i) begin
    adv_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_word(s_axis_tdata[0]);
      n_adv++;
    end
  end

  // Driver: present the next advance request, or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !adv_taken)) begin
      if (advance_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= {7'b0, advance_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: compare each digit transfer with the oldest expectation
  always @(posedge clk_i) begin
    digit_rec_t got;
    digit_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{digit: m_axis_tdata[5:0], pos: m_axis_tdata[11:6], last: m_axis_tlast,
              exhausted: m_axis_tuser};
      n_digits++;
      if (digits_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transfer: digit %0d pos %0d last %0b exh %0b",
                   got.digit, got.pos, got.last, got.exhausted);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("digit transfer %0d: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     n_digits, want.digit, want.pos, want.last, want.exhausted,
                     got.digit, got.pos, got.last, got.exhausted);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_MAX) begin
      $display("brute_force_word_enumerator: mismatch");
      $finish;
    end
  end

  // Wait until every request is sent and every digit has come back
  task automatic settle();
    while (advance_q.size() != 0 || s_axis_tvalid || digits_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input bfwe_pkg::cfg_reg_e idx,
                           input logic [bfwe_pkg::LenCfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      bfwe_pkg::REG_LOWER_INDEX: lo_cfg  = val[bfwe_pkg::DigitW-1:0];
      bfwe_pkg::REG_UPPER_INDEX: hi_cfg  = val[bfwe_pkg::DigitW-1:0];
      bfwe_pkg::REG_MIN_LENGTH:  min_cfg = val;
      bfwe_pkg::REG_MAX_LENGTH:  max_cfg = val;
      default: ;
    endcase
  endtask

  // Program all four registers; the block must be idle
  task automatic program_regs(input logic [bfwe_pkg::LenCfgW-1:0] lo_v, hi_v, mn_v, mx_v);
    settle();
    write_reg(bfwe_pkg::REG_LOWER_INDEX, lo_v);
    write_reg(bfwe_pkg::REG_UPPER_INDEX, hi_v);
    write_reg(bfwe_pkg::REG_MIN_LENGTH, mn_v);
    write_reg(bfwe_pkg::REG_MAX_LENGTH, mx_v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic queue_random(input int count, input int restart_pct);
    repeat (count) advance_q.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    int rand_sent;
    int phase;
    int count;
    logic [bfwe_pkg::LenCfgW-1:0] lo_v, hi_v, mn_v, mx_v;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: first word from reset, one step, then restart
    advance_q.push_back(1'b0);
    advance_q.push_back(1'b0);
    advance_q.push_back(1'b1);

    // One-symbol alphabet at the top index, zero min length acts as one;
    // grows to the limit, then stays exhausted until restart
    program_regs(7'd63, 7'd63, 7'd0, 7'd3);
    advance_q.push_back(1'b1);
    repeat (4) advance_q.push_back(1'b0);
    advance_q.push_back(1'b1);

    // Oversized min length and limit: full 32-digit word, then storage limit
    program_regs(7'd5, 7'd5, 7'd100, 7'd64);
    advance_q.push_back(1'b1);
    advance_q.push_back(1'b0);

    // Starting word longer than the limit, then exhaustion at first growth
    program_regs(7'd9, 7'd9, 7'd5, 7'd2);
    advance_q.push_back(1'b1);
    advance_q.push_back(1'b0);

    // Lower above upper: the digit counts through 63 and 0 to the wrap point
    program_regs(7'd62, 7'd1, 7'd1, 7'd1);
    advance_q.push_back(1'b1);
    repeat (4) advance_q.push_back(1'b0);

    // Random settings, cycling through the idle and stall patterns
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(2))
        0: begin
          // tiny alphabet and short limit, which can run into exhaustion
          lo_v = bfwe_pkg::LenCfgW'($urandom_range(61));
          hi_v = lo_v + bfwe_pkg::LenCfgW'($urandom_range(2));
          mn_v = bfwe_pkg::LenCfgW'($urandom_range(4));
          mx_v = bfwe_pkg::LenCfgW'($urandom_range(6));
        end
        1: begin
          // wrap point below the lower index
          lo_v = bfwe_pkg::LenCfgW'($urandom_range(63, 1));
          hi_v = bfwe_pkg::LenCfgW'($urandom_range(lo_v - 1));
          mn_v = bfwe_pkg::LenCfgW'($urandom_range(3, 1));
          mx_v = bfwe_pkg::LenCfgW'($urandom_range(4, 1));
        end
        default: begin
          lo_v = bfwe_pkg::LenCfgW'($urandom_range(127));
          hi_v = bfwe_pkg::LenCfgW'($urandom_range(127));
          mn_v = bfwe_pkg::LenCfgW'(($urandom_range(4) == 0) ? $urandom_range(127)
                                                              : $urandom_range(6));
          mx_v = bfwe_pkg::LenCfgW'($urandom_range(127));
        end
      endcase
      program_regs(lo_v, hi_v, mn_v, mx_v);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      count = $urandom_range(30, 15);
      advance_q.push_back(1'($urandom_range(1)));
      queue_random(count - 1, 8);
      rand_sent += count;
      phase++;
    end

    settle();
    if (digits_due.size() != 0) mismatches++;
    $display("advances %0d, digit transfers %0d, exhausted reports %0d, settings %0d",
             n_adv, n_digits, n_spent, n_settings);
    $display("mismatches %0d", mismatches);
    if (mismatches == 0)
      $display("brute_force_word_enumerator: match");
    else
      $display("brute_force_word_enumerator: mismatch");
    $finish;
  end

endmodule
